// ===== design/branch_history_top4_feature_encoder_assert.svh =====
// Assertion macros for the branch history feature encoder.
`ifndef BRANCH_HISTORY_TOP4_FEATURE_ENCODER_ASSERT_SVH
`define BRANCH_HISTORY_TOP4_FEATURE_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BHFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BHFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BHFE_ASSERT_NOW(label, ante, cons)
`define BHFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/bhfe_pkg.sv =====
// Shared types, constants and the slot-hit function of the branch history feature encoder.
`timescale 1ns / 1ps
package bhfe_pkg;
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int TOP_SLOTS = 4;
  localparam int KIND_CODES = 3;
  localparam logic [7:0] LOW_BYTE = 8'hFF;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] branch_address;
    logic [63:0] target_address;
    logic [7:0]  kind_code;
    logic        outcome_taken;
  } in_t;

  typedef struct packed {
    logic [5:0] row_index;
    logic       taken_bit;
    logic [3:0] address_slot_hits;
    logic [3:0] target_slot_hits;
    logic [2:0] kind_onehot;
    logic       last_row;
  } out_t;

  typedef struct packed {
    logic       taken;
    logic [7:0] kind;
    logic [7:0] target;
    logic [7:0] addr;
  } entry_t;

  typedef struct packed {
    logic       clear;
    logic       lookup;
    logic [7:0] value;
  } topk_ctrl_t;

  typedef struct packed {
    logic [TOP_SLOTS-1:0][7:0] slot;
    logic [2:0]                used;
  } slot_list_t;

  function automatic logic [TOP_SLOTS-1:0] slot_hits(logic [7:0] byte_v, slot_list_t list);
    logic [TOP_SLOTS-1:0] h;
    h = '0;
    for (int s = 0; s < TOP_SLOTS; s++) begin
      if ((3'(s) < list.used) && (list.slot[s] == byte_v)) h[s] = 1'b1;
    end
    return h;
  endfunction
endpackage

// ===== design/bhfe_hist_mem.sv =====
// History window memory: one write port, one registered read port.
`timescale 1ns / 1ps
module bhfe_hist_mem #(
  parameter int DEPTH = bhfe_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  bhfe_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output bhfe_pkg::entry_t rdata_o
);
  import bhfe_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/bhfe_topk.sv =====
// Top-four frequency list unit: count memory lookup, then update of the slot list.
`timescale 1ns / 1ps
module bhfe_topk #(
  parameter int DEPTH = bhfe_pkg::HISTORY_DEPTH_DEF,
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bhfe_pkg::topk_ctrl_t ctrl_i,
  input  logic [POS_W-1:0]     pos_i,
  output bhfe_pkg::slot_list_t list_o
);
  import bhfe_pkg::*;

  logic [CNT_W+POS_W-1:0] cnt_mem_q [256];
  logic [CNT_W+POS_W-1:0] rd_q;
  logic [255:0]           vld_q;
  logic                   lookup_q;
  logic [7:0]             v_q;
  logic [POS_W-1:0]       pos_q;

  logic [TOP_SLOTS-1:0][7:0]       slot_q;
  logic [TOP_SLOTS-1:0][CNT_W-1:0] scnt_q;
  logic [TOP_SLOTS-1:0][POS_W-1:0] sfirst_q;
  logic [2:0]                      used_q;

  logic [CNT_W-1:0]     cnt_new;
  logic [POS_W-1:0]     first_v;
  logic [TOP_SLOTS-1:0] hit;
  logic [1:0]           low_idx;
  logic                 replace;

  always_comb begin
    // A value not yet seen in this pass counts from zero and takes this position.
    if (vld_q[v_q]) begin
      cnt_new = rd_q[CNT_W+POS_W-1:POS_W] + CNT_W'(1);
      first_v = rd_q[POS_W-1:0];
    end else begin
      cnt_new = CNT_W'(1);
      first_v = pos_q;
    end
    for (int s = 0; s < TOP_SLOTS; s++) begin
      hit[s] = (3'(s) < used_q) && (slot_q[s] == v_q);
    end
    low_idx = 2'd0;
    for (int s = 1; s < TOP_SLOTS; s++) begin
      if ((scnt_q[s] < scnt_q[low_idx]) ||
          ((scnt_q[s] == scnt_q[low_idx]) && (sfirst_q[s] < sfirst_q[low_idx]))) begin
        low_idx = 2'(s);
      end
    end
    replace = (cnt_new > scnt_q[low_idx]) ||
              ((cnt_new == scnt_q[low_idx]) && (first_v > sfirst_q[low_idx]));
  end

  always_ff @(posedge clk_i) begin
    if (lookup_q) cnt_mem_q[v_q] <= {cnt_new, first_v};
    if (ctrl_i.lookup) rd_q <= cnt_mem_q[ctrl_i.value];
    if (ctrl_i.lookup) begin
      v_q   <= ctrl_i.value;
      pos_q <= pos_i;
    end
    if (!ctrl_i.clear && lookup_q) begin
      for (int s = 0; s < TOP_SLOTS; s++) begin
        if (hit[s]) scnt_q[s] <= cnt_new;
      end
      if (hit == '0) begin
        if (used_q < 3'(TOP_SLOTS)) begin
          slot_q[used_q[1:0]]   <= v_q;
          scnt_q[used_q[1:0]]   <= cnt_new;
          sfirst_q[used_q[1:0]] <= first_v;
        end else if (replace) begin
          slot_q[low_idx]   <= v_q;
          scnt_q[low_idx]   <= cnt_new;
          sfirst_q[low_idx] <= first_v;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      used_q   <= '0;
      lookup_q <= 1'b0;
    end else begin
      lookup_q <= ctrl_i.lookup;
      if (ctrl_i.clear) begin
        vld_q  <= '0;
        used_q <= '0;
      end else if (lookup_q) begin
        vld_q[v_q] <= 1'b1;
        if ((hit == '0) && (used_q < 3'(TOP_SLOTS))) used_q <= used_q + 3'd1;
      end
    end
  end

  assign list_o.slot = slot_q;
  assign list_o.used = used_q;
endmodule

// ===== design/branch_history_top4_feature_encoder.sv =====
// Top level of the branch history feature encoder.
`timescale 1ns / 1ps
// A record word (mode 0) is written to the history and busy stays low. A request word
// (mode 1) holds busy high while it scans the H entries held and emits the rows,
// H being the number of entries held: each window entry takes two steps per list,
// one to read the history memory and one to read and update the count memory of the
// shared top-four unit, and the rows then stream out one per cycle. Results appear on
// result_o for one cycle, marked by result_valid_o, DEPTH rows per request, oldest
// first; the receiver cannot stall them, so it must take every row as it comes.
module branch_history_top4_feature_encoder #(
  parameter int DEPTH = bhfe_pkg::HISTORY_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bhfe_pkg::in_t  req_i,
  output logic           result_valid_o,
  output bhfe_pkg::out_t result_o
);
  import bhfe_pkg::*;

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_LK = 3'd2;
  localparam logic [2:0] S_NEXT    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [POS_W-1:0] oldest_q, oldest_d;
  logic             pass_q, pass_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] row_q, row_d;
  slot_list_t       addr_list_q;
  logic             e1_valid_q, e1_real_q, e1_last_q;
  logic [POS_W-1:0] e1_row_q;
  out_t             result_q;
  logic             result_valid_q;

  logic             we, re;
  logic [POS_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  topk_ctrl_t       tk_ctrl;
  slot_list_t       tk_list;
  logic [CNT_W-1:0] pad;
  logic             row_real, row_last;

  function automatic logic [POS_W-1:0] wrap_add(logic [POS_W-1:0] base, logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[POS_W-1:0];
  endfunction

  assign pad      = CNT_W'(DEPTH) - held_q;
  assign row_real = CNT_W'(row_q) >= pad;
  assign row_last = row_q == POS_W'(DEPTH - 1);

  assign wdata.addr   = req_i.branch_address[7:0] & LOW_BYTE;
  assign wdata.target = req_i.target_address[7:0] & LOW_BYTE;
  assign wdata.kind   = req_i.kind_code;
  assign wdata.taken  = req_i.outcome_taken;
  assign waddr = (held_q < CNT_W'(DEPTH)) ? wrap_add(oldest_q, held_q) : oldest_q;

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    oldest_d = oldest_q;
    pass_d   = pass_q;
    pos_d    = pos_q;
    row_d    = row_q;
    we       = 1'b0;
    re       = 1'b0;
    raddr    = wrap_add(oldest_q, pos_q);
    tk_ctrl.clear  = 1'b0;
    tk_ctrl.lookup = 1'b0;
    tk_ctrl.value  = pass_q ? rdata.target : rdata.addr;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.mode == MODE_RECORD) begin
            we = 1'b1;
            if (held_q < CNT_W'(DEPTH)) begin
              held_d = held_q + CNT_W'(1);
            end else begin
              oldest_d = wrap_add(oldest_q, CNT_W'(1));
            end
          end else begin
            tk_ctrl.clear = 1'b1;
            pass_d  = 1'b0;
            pos_d   = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (pos_q == held_q) begin
          state_d = S_NEXT;
        end else begin
          re      = 1'b1;
          state_d = S_SCAN_LK;
        end
      end
      S_SCAN_LK: begin
        tk_ctrl.lookup = 1'b1;
        pos_d   = pos_q + CNT_W'(1);
        state_d = S_SCAN_RD;
      end
      S_NEXT: begin
        if (!pass_q) begin
          tk_ctrl.clear = 1'b1;
          pass_d  = 1'b1;
          pos_d   = '0;
          state_d = S_SCAN_RD;
        end else begin
          row_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        re    = row_real;
        raddr = wrap_add(oldest_q, CNT_W'(row_q) - pad);
        row_d = row_q + POS_W'(1);
        if (row_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  bhfe_hist_mem #(.DEPTH(DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bhfe_topk #(.DEPTH(DEPTH)) u_topk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tk_ctrl),
    .pos_i  (pos_q[POS_W-1:0]),
    .list_o (tk_list)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      held_q         <= '0;
      oldest_q       <= '0;
      pass_q         <= 1'b0;
      pos_q          <= '0;
      row_q          <= '0;
      e1_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      held_q         <= held_d;
      oldest_q       <= oldest_d;
      pass_q         <= pass_d;
      pos_q          <= pos_d;
      row_q          <= row_d;
      e1_valid_q     <= state_q == S_EMIT;
      result_valid_q <= e1_valid_q;
    end
  end

  // Address list is frozen at the end of the first pass; the target list stays in the unit.
  always_ff @(posedge clk_i) begin
    if (state_q == S_NEXT && !pass_q) addr_list_q <= tk_list;
    e1_row_q  <= row_q;
    e1_real_q <= row_real;
    e1_last_q <= row_last;
    result_q.row_index <= 6'(e1_row_q);
    result_q.last_row  <= e1_last_q;
    if (e1_real_q) begin
      result_q.taken_bit         <= rdata.taken;
      result_q.address_slot_hits <= slot_hits(rdata.addr, addr_list_q);
      result_q.target_slot_hits  <= slot_hits(rdata.target, tk_list);
      for (int k = 0; k < KIND_CODES; k++) begin
        result_q.kind_onehot[k] <= rdata.kind == 8'(k);
      end
    end else begin
      result_q.taken_bit         <= 1'b0;
      result_q.address_slot_hits <= '0;
      result_q.target_slot_hits  <= '0;
      result_q.kind_onehot       <= '0;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`include "branch_history_top4_feature_encoder_assert.svh"

  `BHFE_ASSERT_NEXT(a_req_goes_busy, start && !busy && req_i.mode == MODE_REQUEST, busy)
  `BHFE_ASSERT_NEXT(a_gap_after_last, result_valid_o && result_o.last_row, !result_valid_o)
  `BHFE_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_W'(DEPTH))
  `BHFE_ASSERT_NOW(a_no_row_when_scanning, state_q == S_SCAN_LK, !e1_valid_q)
endmodule

// ===== test/tb_branch_history_top4_feature_encoder.sv =====
// Self-checking testbench of the branch history feature encoder.
`timescale 1ns / 1ps
module tb_branch_history_top4_feature_encoder;
  import bhfe_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t req_i = '0;
  logic result_valid_o;
  out_t result_o;

  branch_history_top4_feature_encoder #(.DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the branch window and its fill level.
  entry_t window_q[DEPTH];
  int held_cnt = 0;
  int oldest_idx = 0;

  in_t pending_words[$];
  out_t expected_rows[$];
  int fail_cnt = 0;
  bit quiet_tail = 1'b0;
  bit hold_off = 1'b0;

  function automatic entry_t entry_at(int pos);
    return window_q[(oldest_idx + pos) % DEPTH];
  endfunction

  // Top-four list over one byte of the window, scanned oldest first.
  function automatic void build_top4(bit use_target, output logic [7:0] slots[4],
                                     output int used);
    int cnt[256];
    int first_pos[256];
    logic [7:0] v;
    bit present;
    int w;
    for (int i = 0; i < 256; i++) begin
      cnt[i] = 0;
      first_pos[i] = 0;
    end
    for (int i = 0; i < 4; i++) slots[i] = '0;
    used = 0;
    for (int pos = 0; pos < held_cnt; pos++) begin
      v = use_target ? entry_at(pos).target : entry_at(pos).addr;
      if (cnt[v] == 0) first_pos[v] = pos;
      cnt[v]++;
      present = 1'b0;
      for (int s = 0; s < used; s++) if (slots[s] == v) present = 1'b1;
      if (present) continue;
      if (used < 4) begin
        slots[used] = v;
        used++;
      end else begin
        w = 0;
        for (int s = 1; s < 4; s++) begin
          if (cnt[slots[s]] < cnt[slots[w]] ||
              (cnt[slots[s]] == cnt[slots[w]] && first_pos[slots[s]] < first_pos[slots[w]]))
            w = s;
        end
        if (cnt[v] > cnt[slots[w]] ||
            (cnt[v] == cnt[slots[w]] && first_pos[v] > first_pos[slots[w]]))
          slots[w] = v;
      end
    end
  endfunction

  function automatic logic [3:0] hits_of(logic [7:0] b, logic [7:0] slots[4], int used);
    logic [3:0] h;
    h = '0;
    for (int s = 0; s < used; s++) if (slots[s] == b) h[s] = 1'b1;
    return h;
  endfunction

  task automatic predict_word(in_t w);
    entry_t e;
    logic [7:0] addr_slots[4];
    logic [7:0] tgt_slots[4];
    int addr_used;
    int tgt_used;
    int pad;
    out_t r;
    if (w.mode == MODE_RECORD) begin
      e.addr = w.branch_address[7:0];
      e.target = w.target_address[7:0];
      e.kind = w.kind_code;
      e.taken = w.outcome_taken;
      if (held_cnt < DEPTH) begin
        window_q[(oldest_idx + held_cnt) % DEPTH] = e;
        held_cnt++;
      end else begin
        window_q[oldest_idx] = e;
        oldest_idx = (oldest_idx + 1) % DEPTH;
      end
      return;
    end
    build_top4(1'b0, addr_slots, addr_used);
    build_top4(1'b1, tgt_slots, tgt_used);
    pad = DEPTH - held_cnt;
    for (int row = 0; row < DEPTH; row++) begin
      r = '0;
      r.row_index = 6'(row);
      r.last_row = (row == DEPTH - 1);
      if (row >= pad) begin
        e = entry_at(row - pad);
        r.taken_bit = e.taken;
        r.address_slot_hits = hits_of(e.addr, addr_slots, addr_used);
        r.target_slot_hits = hits_of(e.target, tgt_slots, tgt_used);
        r.kind_onehot = (e.kind < 3) ? 3'(1 << e.kind) : 3'b000;
      end
      expected_rows.insert(expected_rows.size(), r);
    end
  endtask

  task automatic enqueue_word(in_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic in_t make_record(logic [63:0] a, logic [63:0] t, logic [7:0] k,
                                      logic tk);
    in_t w;
    w.mode = MODE_RECORD;
    w.branch_address = a;
    w.target_address = t;
    w.kind_code = k;
    w.outcome_taken = tk;
    return w;
  endfunction

  function automatic in_t make_request();
    in_t w;
    w.mode = MODE_REQUEST;
    w.branch_address = {$urandom, $urandom};
    w.target_address = {$urandom, $urandom};
    w.kind_code = 8'($urandom);
    w.outcome_taken = 1'($urandom);
    return w;
  endfunction

  // Driver: a word is taken at an edge with start high and busy low.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_word(req_i);
        pending_words.delete(0);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (hold_off || pending_words.size() == 0) begin
          start <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 6);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          req_i <= pending_words[0];
        end
      end
    end
  end

  // Monitor: compare every row with the oldest expectation.
  always @(posedge clk_i) begin
    out_t x;
    if (rst_ni && result_valid_o) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected row %p", result_o);
        fail_cnt++;
      end else begin
        x = expected_rows[0];
        expected_rows.delete(0);
        if (result_o.row_index !== x.row_index) begin
          $error("row_index exp %0d got %0d", x.row_index, result_o.row_index); fail_cnt++;
        end
        if (result_o.taken_bit !== x.taken_bit) begin
          $error("taken_bit exp %0d got %0d", x.taken_bit, result_o.taken_bit); fail_cnt++;
        end
        if (result_o.address_slot_hits !== x.address_slot_hits) begin
          $error("address_slot_hits exp %h got %h", x.address_slot_hits,
                 result_o.address_slot_hits); fail_cnt++;
        end
        if (result_o.target_slot_hits !== x.target_slot_hits) begin
          $error("target_slot_hits exp %h got %h", x.target_slot_hits,
                 result_o.target_slot_hits); fail_cnt++;
        end
        if (result_o.kind_onehot !== x.kind_onehot) begin
          $error("kind_onehot exp %h got %h", x.kind_onehot, result_o.kind_onehot); fail_cnt++;
        end
        if (result_o.last_row !== x.last_row) begin
          $error("last_row exp %0d got %0d", x.last_row, result_o.last_row); fail_cnt++;
        end
      end
    end
  end

  int cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Small byte pool so that counts repeat and slots get displaced.
  function automatic logic [63:0] rand_addr();
    logic [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) a[7:0] = 8'($urandom_range(0, 9));
    return a;
  endfunction

  initial begin
    logic [7:0] k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: empty history, extremes, every kind, a slot tie.
    enqueue_word(make_request());
    enqueue_word(make_record('0, '0, 8'd0, 1'b0));
    enqueue_word(make_request());
    enqueue_word(make_record('1, '1, 8'hFF, 1'b1));
    enqueue_word(make_record(64'h5, 64'h7, 8'd1, 1'b1));
    enqueue_word(make_record(64'h6, 64'h8, 8'd2, 1'b0));
    enqueue_word(make_record(64'h9, 64'h7, 8'd3, 1'b1));
    enqueue_word(make_record(64'h5, 64'h9, 8'd1, 1'b0));
    enqueue_word(make_request());
    wait (pending_words.size() == 0);
    // Hold off the sender until every row of the directed part is in.
    hold_off = 1'b1;
    wait (expected_rows.size() == 0);
    repeat (10) @(posedge clk_i);
    hold_off = 1'b0;
    for (int i = 0; i < 130; i++) begin
      if ($urandom_range(0, 6) == 0) enqueue_word(make_request());
      else begin
        k = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        enqueue_word(make_record(rand_addr(), rand_addr(), k, 1'($urandom)));
      end
    end
    enqueue_word(make_request());
    // The last stretch of words goes out with no random gaps between them.
    wait (pending_words.size() <= 20);
    quiet_tail = 1'b1;
    wait (pending_words.size() == 0);
    wait (expected_rows.size() == 0);
    repeat (4 * DEPTH + DEPTH + 20) @(posedge clk_i);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
